// ===== rtl/dmwl_pkg.sv =====
// ----------------------------------------------------------------------------
// dmwl_pkg
// Shared types and constants of the monochrome window and level core:
// register map, pipeline region codes and the divider stage record.
// ----------------------------------------------------------------------------
package dmwl_pkg;

  localparam int PADDR_W = 5;

  localparam logic [2:0] REG_PIXEL_IS_BYTE     = 3'd0;
  localparam logic [2:0] REG_RESCALE_SLOPE     = 3'd1;
  localparam logic [2:0] REG_RESCALE_INTERCEPT = 3'd2;
  localparam logic [2:0] REG_WINDOW_CENTER     = 3'd3;
  localparam logic [2:0] REG_WINDOW_WIDTH      = 3'd4;

  localparam int REM_W = 30;
  localparam int DV_W  = 21;
  localparam int QUO_W = 8;

  typedef enum logic [1:0] {
    REGION_PAD  = 2'd0,
    REGION_LOW  = 2'd1,
    REGION_HIGH = 2'd2,
    REGION_MID  = 2'd3
  } region_t;

  typedef struct packed {
    region_t            region;
    logic               sat;
    logic [REM_W-1:0]   rem;
    logic [QUO_W-1:0]   quo;
  } div_t;

endpackage

// ===== rtl/dicom_mono_window_level_core.sv =====
// ----------------------------------------------------------------------------
// dicom_mono_window_level_core
// One pixel is taken per cycle while out_ready does not stall the output,
// set by the 15-stage pipeline with a one-bit-per-stage divider.
// Each stage advances on its own, so bubbles are squeezed out under stall.
// Synchronous reset clears all valid bits, the padding latch and the
// registers to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dicom_mono_window_level_core
  import dmwl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [15:0]        raw_pixel,
  input  logic                      frame_start,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                gray_level,
  output logic                      was_padding
);

  localparam int NS = 15;
  localparam int ND = 7;

  localparam logic signed [33:0] BYTE_MAX = 34'sd255;
  localparam logic signed [33:0] WORD_MAX = 34'sd32767;
  localparam logic signed [33:0] WORD_MIN = -34'sd32768;

  logic                     pixel_is_byte;
  logic signed [31:0]       rescale_slope;
  logic signed [23:0]       rescale_intercept;
  logic signed [20:0]       window_center;
  logic [19:0]              window_width;
  logic [15:0]              padding_latch;

  logic signed [17:0]       lower;
  logic signed [17:0]       upper;
  logic [DV_W-1:0]          dv;
  logic [REM_W-1:0]         t255;

  logic signed [22:0]       lo_arg;
  logic signed [22:0]       hi_arg;
  logic signed [22:0]       lo_adj;
  logic signed [22:0]       hi_adj;
  logic [19:0]              wm16;

  logic [NS-1:0]            valid;
  logic [NS-1:0]            adv;

  logic                     s1_pad;
  logic signed [16:0]       s1_pix;
  logic                     s2_pad;
  logic signed [48:0]       s2_prod;
  logic                     s3_pad;
  logic signed [49:0]       s3_sum;
  logic                     s4_pad;
  logic signed [33:0]       s4_trunc;
  logic                     s5_pad;
  logic signed [15:0]       s5_p;
  region_t                  s6_region;
  logic signed [24:0]       s6_y;
  region_t                  s7_region;
  logic [REM_W-1:0]         s7_x;

  div_t                     div_st [ND];
  div_t                     div_in [ND];
  div_t                     div_next [ND];

  logic                     wr_en;
  logic [15:0]              pad_ref;
  logic [15:0]              cmp_mask;
  logic                     pad_hit;
  logic signed [16:0]       pix_sel;
  logic signed [49:0]       sum_next;
  logic signed [49:0]       sum_bias;
  logic signed [15:0]       p_next;
  logic signed [17:0]       p_ext;
  region_t                  region_next;
  logic signed [24:0]       y_next;
  logic [21:0]              y_low;
  logic [REM_W-1:0]         x_next;
  logic [REM_W-1:0]         dsh;
  logic [REM_W-1:0]         last_dsh;
  logic                     last_bit;
  logic [7:0]               gray_next;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_is_byte     <= 1'b0;
      rescale_slope     <= 32'sd65536;
      rescale_intercept <= 24'sd0;
      window_center     <= 21'sd6400;
      window_width      <= 20'd32000;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_PIXEL_IS_BYTE:     pixel_is_byte     <= pwdata[0];
        REG_RESCALE_SLOPE:     rescale_slope     <= pwdata;
        REG_RESCALE_INTERCEPT: rescale_intercept <= pwdata[23:0];
        REG_WINDOW_CENTER:     window_center     <= pwdata[20:0];
        REG_WINDOW_WIDTH:      window_width      <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_PIXEL_IS_BYTE:     prdata = {31'd0, pixel_is_byte};
      REG_RESCALE_SLOPE:     prdata = rescale_slope;
      REG_RESCALE_INTERCEPT: prdata = {8'd0, rescale_intercept};
      REG_WINDOW_CENTER:     prdata = {11'd0, window_center};
      REG_WINDOW_WIDTH:      prdata = {12'd0, window_width};
      default:               prdata = 32'd0;
    endcase
  end

  // Window bounds and divisor are registered from the configuration registers.
  always_comb begin
    lo_arg = {window_center[20], window_center, 1'b0} - $signed({3'd0, window_width});
    hi_arg = {window_center[20], window_center, 1'b0} + $signed({3'd0, window_width})
             - 23'sd32;
    lo_adj = lo_arg + (lo_arg[22] ? 23'sd31 : 23'sd0);
    hi_adj = hi_arg + (hi_arg[22] ? 23'sd31 : 23'sd0);
    wm16   = window_width - 20'd16;
  end

  always_ff @(posedge clk) begin
    lower <= lo_adj[22:5];
    upper <= hi_adj[22:5];
    dv    <= {wm16, 1'b0};
    t255  <= {1'b0, dv, 8'd0} - {9'd0, dv};
  end

  always_comb begin
    adv[NS-1] = !valid[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !valid[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = valid[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= '0;
      padding_latch <= 16'd0;
    end else begin
      if (adv[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) begin
          valid[i] <= valid[i-1];
        end
      end
      if (in_valid && in_ready && frame_start) begin
        padding_latch <= raw_pixel;
      end
    end
  end

  always_comb begin
    pad_ref  = frame_start ? raw_pixel : padding_latch;
    cmp_mask = pixel_is_byte ? 16'h00FF : 16'hFFFF;
    pad_hit  = ((raw_pixel ^ pad_ref) & cmp_mask) == 16'd0;
    pix_sel  = pixel_is_byte ? $signed({9'd0, raw_pixel[7:0]})
                             : $signed({raw_pixel[15], raw_pixel});

    sum_next = $signed({s2_prod[48], s2_prod})
               + $signed({{18{rescale_intercept[23]}}, rescale_intercept, 8'd0});
    sum_bias = s3_sum + (s3_sum[49] ? 50'sd65535 : 50'sd0);

    if (pixel_is_byte) begin
      if (s4_trunc < 34'sd0) begin
        p_next = 16'sd0;
      end else if (s4_trunc > BYTE_MAX) begin
        p_next = 16'sd255;
      end else begin
        p_next = s4_trunc[15:0];
      end
    end else begin
      if (s4_trunc < WORD_MIN) begin
        p_next = -16'sd32768;
      end else if (s4_trunc > WORD_MAX) begin
        p_next = 16'sd32767;
      end else begin
        p_next = s4_trunc[15:0];
      end
    end

    p_ext = {{2{s5_p[15]}}, s5_p};
    if (s5_pad) begin
      region_next = REGION_PAD;
    end else if (p_ext <= lower) begin
      region_next = REGION_LOW;
    end else if (p_ext > upper) begin
      region_next = REGION_HIGH;
    end else begin
      region_next = REGION_MID;
    end
    y_next = $signed({{4{s5_p[15]}}, s5_p, 5'd0})
             - $signed({{3{window_center[20]}}, window_center, 1'b0})
             + $signed({5'd0, window_width});

    y_low  = s6_y[21:0];
    x_next = {y_low, 8'd0} - {8'd0, y_low};
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_pad <= pad_hit;
      s1_pix <= pix_sel;
    end
    if (adv[1]) begin
      s2_pad  <= s1_pad;
      s2_prod <= s1_pix * rescale_slope;
    end
    if (adv[2]) begin
      s3_pad <= s2_pad;
      s3_sum <= sum_next;
    end
    if (adv[3]) begin
      s4_pad   <= s3_pad;
      s4_trunc <= sum_bias[49:16];
    end
    if (adv[4]) begin
      s5_pad <= s4_pad;
      s5_p   <= p_next;
    end
    if (adv[5]) begin
      s6_region <= region_next;
      s6_y      <= y_next;
    end
    if (adv[6]) begin
      s7_region <= s6_region;
      s7_x      <= x_next;
    end
  end

  // Restoring division of the interior term by 2(W-1), one quotient bit per stage.
  always_comb begin
    div_in[0].region = s7_region;
    div_in[0].sat    = s7_x >= t255;
    div_in[0].rem    = s7_x;
    div_in[0].quo    = '0;
    for (int j = 1; j < ND; j++) begin
      div_in[j] = div_st[j-1];
    end
    for (int j = 0; j < ND; j++) begin
      dsh         = {{(REM_W-DV_W){1'b0}}, dv} << (QUO_W - 1 - j);
      div_next[j] = div_in[j];
      if (div_in[j].rem >= dsh) begin
        div_next[j].rem              = div_in[j].rem - dsh;
        div_next[j].quo[QUO_W-1-j]   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < ND; j++) begin
      if (adv[7+j]) begin
        div_st[j] <= div_next[j];
      end
    end
  end

  always_comb begin
    last_dsh = {{(REM_W-DV_W){1'b0}}, dv};
    last_bit = div_st[ND-1].rem >= last_dsh;
    case (div_st[ND-1].region)
      REGION_PAD:  gray_next = 8'd0;
      REGION_LOW:  gray_next = 8'd0;
      REGION_HIGH: gray_next = 8'd255;
      REGION_MID:  gray_next = div_st[ND-1].sat ? 8'd255
                                                : {div_st[ND-1].quo[7:1], last_bit};
      default:     gray_next = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      gray_level  <= gray_next;
      was_padding <= div_st[ND-1].region == REGION_PAD;
    end
  end

endmodule
